// ----- rtl/tpca_pkg.sv -----
`timescale 1ns / 1ps
// Package for track_pair_closest_approach: widths, payload and job types,
// status codes. No dependencies.
package tpca_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int VEL_WIDTH   = 32;

    localparam int POS_SHIFT = 24;
    localparam int MID_SHIFT = 25;
    localparam int SEP_SHIFT = 16;
    localparam int SQ_SHIFT  = 16;

    localparam int MUL_A_W = COORD_WIDTH + 34;
    localparam int MUL_B_W = (COORD_WIDTH + 9 > 38) ? COORD_WIDTH + 9 : 38;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SQRT_W  = 2 * COORD_WIDTH + 4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_PARALLEL = 2'd1;
    localparam logic [1:0] ST_NOHELD   = 2'd2;
    localparam logic [1:0] ST_SAT      = 2'd3;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
        logic signed [COORD_WIDTH-1:0] pos_z;
        logic signed [COORD_WIDTH-1:0] ref_time;
        logic signed [VEL_WIDTH-1:0]   vel_x;
        logic signed [VEL_WIDTH-1:0]   vel_y;
        logic signed [VEL_WIDTH-1:0]   vel_z;
        logic                          pair_second;
    } in_t;

    typedef struct packed {
        logic [COORD_WIDTH-1:0]        separation;
        logic signed [COORD_WIDTH-1:0] mid_x;
        logic signed [COORD_WIDTH-1:0] mid_y;
        logic signed [COORD_WIDTH-1:0] mid_z;
        logic signed [COORD_WIDTH-1:0] mid_time;
        logic [1:0]                    status;
    } out_t;

    typedef struct packed {
        logic [2:0][COORD_WIDTH-1:0] pos;
        logic [COORD_WIDTH-1:0]      t0;
        logic [2:0][VEL_WIDTH-1:0]   vel;
    } track_t;

    typedef struct packed {
        logic   has_pair;
        track_t first;
        track_t second;
    } job_t;

endpackage

// ----- rtl/track_pair_closest_approach.sv -----
`timescale 1ns / 1ps
// Closest approach of two straight tracks. A transaction with pair_second low
// is held as the first track; a second track is queued (two deep) and worked
// through a bit-serial 66x41 multiplier for up to 21 products, a radix-2 divider
// and a radix-4 square root. A parallel pair ends after the three velocity
// products; a second track without a held track skips all arithmetic and is
// flagged ST_NOHELD. Results wait in an output register.
// Depends on tpca_pkg, tpca_front, tpca_queue, tpca_back.
module track_pair_closest_approach (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tpca_pkg::in_t  item,
    output logic           full,
    output logic           empty,
    input  logic           pop,
    output tpca_pkg::out_t result
);

    logic           q_wr, q_full, q_rd, q_valid;
    tpca_pkg::job_t q_wdata, q_rdata;

    tpca_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .full    (full),
        .q_full  (q_full),
        .q_wr    (q_wr),
        .q_wdata (q_wdata)
    );

    tpca_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wdata   (q_wdata),
        .q_full  (q_full),
        .rd      (q_rd),
        .rdata   (q_rdata),
        .q_valid (q_valid)
    );

    tpca_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (q_rdata),
        .job_valid (q_valid),
        .job_rd    (q_rd),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr |-> !q_full)
        else $error("job queue written while full");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd |-> q_valid)
        else $error("job queue read while empty");

    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.status == tpca_pkg::ST_PARALLEL
                    || result.status == tpca_pkg::ST_NOHELD))
        |-> (result.separation == '0 && result.mid_time == '0
             && result.mid_x == '0 && result.mid_y == '0 && result.mid_z == '0))
        else $error("nonzero fields on parallel or unpaired transaction");

endmodule

// ----- rtl/tpca_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts transactions, holds the first track, builds pair jobs.
// Depends on tpca_pkg.
module tpca_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tpca_pkg::in_t    item,
    output logic             full,
    input  logic             q_full,
    output logic             q_wr,
    output tpca_pkg::job_t   q_wdata
);

    tpca_pkg::track_t held_reg, held_next;
    logic             held_valid_reg, held_valid_next;
    tpca_pkg::track_t cur;
    logic             accept;

    always_comb
    begin
        cur.pos = {item.pos_z, item.pos_y, item.pos_x};
        cur.t0  = item.ref_time;
        cur.vel = {item.vel_z, item.vel_y, item.vel_x};
        full    = q_full;
        accept  = push && !q_full;
        q_wr    = accept && item.pair_second;
        q_wdata.has_pair = held_valid_reg;
        q_wdata.first    = held_reg;
        q_wdata.second   = cur;
        held_next        = held_reg;
        held_valid_next  = held_valid_reg;
        if (accept)
        begin
            if (!item.pair_second)
            begin
                held_next       = cur;
                held_valid_next = 1'b1;
            end
            else
            begin
                held_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
        end
    end

endmodule

// ----- rtl/tpca_queue.sv -----
`timescale 1ns / 1ps
// Two-entry job queue between front end and back end.
// Depends on tpca_pkg.
module tpca_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  tpca_pkg::job_t wdata,
    output logic           q_full,
    input  logic           rd,
    output tpca_pkg::job_t rdata,
    output logic           q_valid
);

    tpca_pkg::job_t mem [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    always_comb
    begin
        q_full   = cnt_reg == 2'd2;
        q_valid  = cnt_reg != 2'd0;
        rdata    = mem[rp_reg];
        wp_next  = wp_reg ^ wr;
        rp_next  = rp_reg ^ rd;
        cnt_next = cnt_reg + 2'(wr) - 2'(rd);
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- rtl/tpca_mul.sv -----
`timescale 1ns / 1ps
// Shift-add signed multiplier, one bit of b per cycle, done pulses with p.
// Depends on tpca_pkg.
module tpca_mul (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [tpca_pkg::MUL_A_W-1:0]   a,
    input  logic signed [tpca_pkg::MUL_B_W-1:0]   b,
    output logic                                  done,
    output logic signed [tpca_pkg::PROD_W-1:0]    p
);

    localparam int AW = tpca_pkg::MUL_A_W;
    localparam int BW = tpca_pkg::MUL_B_W;
    localparam int PW = tpca_pkg::PROD_W;
    localparam int CW = $clog2(BW + 1);

    logic [PW-1:0] acc_reg, acc_next;
    logic [PW-1:0] ash_reg, ash_next;
    logic [BW-1:0] bsh_reg, bsh_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [AW-1:0] a_mag;
    logic [BW-1:0] b_mag;

    always_comb
    begin
        a_mag     = a[AW-1] ? AW'(-a) : AW'(a);
        b_mag     = b[BW-1] ? BW'(-b) : BW'(b);
        acc_next  = acc_reg;
        ash_next  = ash_reg;
        bsh_next  = bsh_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next = '0;
            ash_next = PW'(a_mag);
            bsh_next = b_mag;
            neg_next = a[AW-1] ^ b[BW-1];
            cnt_next = CW'(BW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (bsh_reg[0])
            begin
                acc_next = acc_reg + ash_reg;
            end
            ash_next = ash_reg << 1;
            bsh_next = bsh_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
        done = done_reg;
        p    = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        ash_reg <= ash_next;
        bsh_reg <= bsh_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
    end

endmodule

// ----- rtl/tpca_back.sv -----
`timescale 1ns / 1ps
// Back end: sequences one pair job through the shared multiplier, divider
// and square root steps and loads the result register. Depends on tpca_pkg, tpca_mul.
module tpca_back (
    input  logic           clk,
    input  logic           rst_n,
    input  tpca_pkg::job_t job,
    input  logic           job_valid,
    output logic           job_rd,
    output tpca_pkg::out_t result,
    output logic           empty,
    input  logic           pop
);

    localparam int C   = tpca_pkg::COORD_WIDTH;
    localparam int VW  = tpca_pkg::VEL_WIDTH;
    localparam int MA  = tpca_pkg::MUL_A_W;
    localparam int MB  = tpca_pkg::MUL_B_W;
    localparam int W   = tpca_pkg::PROD_W;
    localparam int SW  = tpca_pkg::SQRT_W;
    localparam int E   = C + 35;
    localparam int MW  = C + 8;
    localparam int CW  = $clog2(C + 3);

    typedef enum logic [3:0] {
        S_IDLE, S_DEN, S_CHK, S_NUM, S_DIVP, S_DIVC, S_DIV, S_TFIN,
        S_POS, S_ROOTP, S_ROOT, S_FIN, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] k_reg, k_next;
    logic [1:0] ph_reg, ph_next;
    logic       issued_reg, issued_next;
    logic signed [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]         den_reg, den_next;
    logic [W-1:0]         n_reg, n_next;
    logic [W-1:0]         rem_reg, rem_next;
    logic [C-1:0]         nlow_reg, nlow_next;
    logic [C-1:0]         q_reg, q_next;
    logic                 neg_reg, neg_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [C-1:0]         t_reg, t_next;
    logic                 sat_reg, sat_next;
    logic                 over_reg, over_next;
    logic signed [MA-1:0] tmp_reg, tmp_next;
    logic signed [MA-1:0] p2_reg, p2_next;
    logic [MW-1:0]        mag_reg, mag_next;
    logic [2:0][C-1:0]    mid_reg, mid_next;
    logic [SW-1:0]        sx_reg, sx_next;
    logic [SW-1:0]        res_reg, res_next;
    logic [SW-1:0]        bit_reg, bit_next;
    tpca_pkg::out_t       rslt_reg, rslt_next;
    tpca_pkg::out_t       out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    logic                 mul_start, mul_done;
    logic signed [MA-1:0] mul_a;
    logic signed [MB-1:0] mul_b;
    logic signed [W-1:0]  mul_p;
    logic signed [MA-1:0] p_ma;

    logic signed [VW-1:0] v1, v2;
    logic signed [C-1:0]  t01, t02, tt;
    logic signed [VW:0]   dv;
    logic signed [C:0]    dt1, dt2;
    logic signed [MA-1:0] r1s, r2s;
    logic signed [E-1:0]  msum, msh, dsum, dsh, dmag;
    logic [C-1:0]         mclamp;
    logic                 mhi, mlo, dover;
    logic signed [W-1:0]  acc_abs;
    logic [W:0]           trial;
    logic [SW-1:0]        tsum;
    logic [C+1:0]         root;
    logic                 root_big;
    logic                 mul_phase;

    tpca_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    always_comb
    begin
        v1   = $signed(job.first.vel[k_reg]);
        v2   = $signed(job.second.vel[k_reg]);
        t01  = $signed(job.first.t0);
        t02  = $signed(job.second.t0);
        tt   = $signed(t_reg);
        dv   = (VW+1)'(v2) - (VW+1)'(v1);
        dt1  = (C+1)'(tt) - (C+1)'(t01);
        dt2  = (C+1)'(tt) - (C+1)'(t02);
        r1s  = MA'($signed(job.first.pos[k_reg])) <<< tpca_pkg::POS_SHIFT;
        r2s  = MA'($signed(job.second.pos[k_reg])) <<< tpca_pkg::POS_SHIFT;
        p_ma = mul_p[MA-1:0];

        msum = E'(tmp_reg) + E'(p2_reg) + (E'(1) <<< (tpca_pkg::MID_SHIFT - 1));
        msh  = msum >>> tpca_pkg::MID_SHIFT;
        mhi  = msh > $signed({{(E-C+1){1'b0}}, {(C-1){1'b1}}});
        mlo  = msh < $signed({{(E-C+1){1'b1}}, {(C-1){1'b0}}});
        if (mhi)
        begin
            mclamp = {1'b0, {(C-1){1'b1}}};
        end
        else if (mlo)
        begin
            mclamp = {1'b1, {(C-1){1'b0}}};
        end
        else
        begin
            mclamp = msh[C-1:0];
        end
        dsum  = E'(tmp_reg) - E'(p2_reg) + (E'(1) <<< (tpca_pkg::SEP_SHIFT - 1));
        dsh   = dsum >>> tpca_pkg::SEP_SHIFT;
        dmag  = dsh[E-1] ? -dsh : dsh;
        dover = |dmag[E-1:MW];

        acc_abs  = acc_reg[W-1] ? -acc_reg : acc_reg;
        trial    = {rem_reg, nlow_reg[C-1]};
        tsum     = res_reg + bit_reg;
        root     = res_reg[C+1:0];
        root_big = |root[C+1:C];

        mul_phase = (state_reg == S_DEN) || (state_reg == S_NUM)
                    || ((state_reg == S_POS) && (ph_reg != 2'd2));
        mul_start = mul_phase && !issued_reg;
        mul_a = MA'(dv);
        mul_b = MB'(dv);
        if (state_reg == S_NUM)
        begin
            case (ph_reg)
                2'd0:
                begin
                    mul_a = MA'(v1);
                    mul_b = MB'(t01);
                end
                2'd1:
                begin
                    mul_a = MA'(v2);
                    mul_b = MB'(t02);
                end
                default:
                begin
                    mul_a = tmp_reg;
                    mul_b = MB'(dv);
                end
            endcase
        end
        else if (state_reg == S_POS)
        begin
            case (ph_reg)
                2'd0:
                begin
                    mul_a = MA'(v1);
                    mul_b = MB'(dt1);
                end
                2'd1:
                begin
                    mul_a = MA'(v2);
                    mul_b = MB'(dt2);
                end
                default:
                begin
                    mul_a = $signed(MA'(mag_reg));
                    mul_b = $signed(MB'(mag_reg));
                end
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        ph_next        = ph_reg;
        issued_next    = issued_reg;
        acc_next       = acc_reg;
        den_next       = den_reg;
        n_next         = n_reg;
        rem_next       = rem_reg;
        nlow_next      = nlow_reg;
        q_next         = q_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        t_next         = t_reg;
        sat_next       = sat_reg;
        over_next      = over_reg;
        tmp_next       = tmp_reg;
        p2_next        = p2_reg;
        mag_next       = mag_reg;
        mid_next       = mid_reg;
        sx_next        = sx_reg;
        res_next       = res_reg;
        bit_next       = bit_reg;
        rslt_next      = rslt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        job_rd         = 1'b0;
        if (mul_start)
        begin
            issued_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    rslt_next   = '0;
                    sat_next    = 1'b0;
                    over_next   = 1'b0;
                    t_next      = '0;
                    mid_next    = '0;
                    acc_next    = '0;
                    k_next      = 2'd0;
                    ph_next     = 2'd0;
                    issued_next = 1'b0;
                    if (!job.has_pair)
                    begin
                        rslt_next.status = tpca_pkg::ST_NOHELD;
                        state_next       = S_OUT;
                    end
                    else
                    begin
                        state_next = S_DEN;
                    end
                end
            end
            S_DEN:
            begin
                if (issued_reg && mul_done)
                begin
                    issued_next = 1'b0;
                    acc_next    = acc_reg + mul_p;
                    if (k_reg == 2'd2)
                    begin
                        state_next = S_CHK;
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end
            S_CHK:
            begin
                den_next = acc_reg;
                acc_next = '0;
                k_next   = 2'd0;
                ph_next  = 2'd0;
                if (acc_reg == '0)
                begin
                    rslt_next.status = tpca_pkg::ST_PARALLEL;
                    state_next       = S_OUT;
                end
                else
                begin
                    state_next = S_NUM;
                end
            end
            S_NUM:
            begin
                if (issued_reg && mul_done)
                begin
                    issued_next = 1'b0;
                    case (ph_reg)
                        2'd0:
                        begin
                            tmp_next = r1s - p_ma;
                            ph_next  = 2'd1;
                        end
                        2'd1:
                        begin
                            tmp_next = tmp_reg - (r2s - p_ma);
                            ph_next  = 2'd2;
                        end
                        default:
                        begin
                            acc_next = acc_reg + mul_p;
                            ph_next  = 2'd0;
                            if (k_reg == 2'd2)
                            begin
                                state_next = S_DIVP;
                            end
                            else
                            begin
                                k_next = k_reg + 2'd1;
                            end
                        end
                    endcase
                end
            end
            S_DIVP:
            begin
                neg_next   = acc_reg[W-1];
                n_next     = W'(acc_abs) + (den_reg >> 1);
                state_next = S_DIVC;
            end
            S_DIVC:
            begin
                k_next   = 2'd0;
                ph_next  = 2'd0;
                acc_next = '0;
                if ({{C{1'b0}}, n_reg} >= {den_reg, {C{1'b0}}})
                begin
                    sat_next   = 1'b1;
                    t_next     = neg_reg ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
                    state_next = S_POS;
                end
                else
                begin
                    rem_next   = W'(n_reg[W-1:C]);
                    nlow_next  = n_reg[C-1:0];
                    q_next     = '0;
                    cnt_next   = CW'(C);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = W'(trial - {1'b0, den_reg});
                    q_next   = {q_reg[C-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[W-1:0];
                    q_next   = {q_reg[C-2:0], 1'b0};
                end
                nlow_next = nlow_reg << 1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    state_next = S_TFIN;
                end
            end
            S_TFIN:
            begin
                if (!neg_reg)
                begin
                    if (q_reg > {1'b0, {(C-1){1'b1}}})
                    begin
                        sat_next = 1'b1;
                        t_next   = {1'b0, {(C-1){1'b1}}};
                    end
                    else
                    begin
                        t_next = q_reg;
                    end
                end
                else
                begin
                    if (q_reg > {1'b1, {(C-1){1'b0}}})
                    begin
                        sat_next = 1'b1;
                        t_next   = {1'b1, {(C-1){1'b0}}};
                    end
                    else
                    begin
                        t_next = -q_reg;
                    end
                end
                state_next = S_POS;
            end
            S_POS:
            begin
                if (ph_reg == 2'd2)
                begin
                    mid_next[k_reg] = mclamp;
                    mag_next        = dmag[MW-1:0];
                    if (mhi || mlo)
                    begin
                        sat_next = 1'b1;
                    end
                    if (dover)
                    begin
                        over_next = 1'b1;
                        sat_next  = 1'b1;
                        ph_next   = 2'd0;
                        if (k_reg == 2'd2)
                        begin
                            state_next = S_ROOTP;
                        end
                        else
                        begin
                            k_next = k_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        ph_next = 2'd3;
                    end
                end
                else if (issued_reg && mul_done)
                begin
                    issued_next = 1'b0;
                    case (ph_reg)
                        2'd0:
                        begin
                            tmp_next = r1s + p_ma;
                            ph_next  = 2'd1;
                        end
                        2'd1:
                        begin
                            p2_next = r2s + p_ma;
                            ph_next = 2'd2;
                        end
                        default:
                        begin
                            acc_next = acc_reg + mul_p;
                            ph_next  = 2'd0;
                            if (k_reg == 2'd2)
                            begin
                                state_next = S_ROOTP;
                            end
                            else
                            begin
                                k_next = k_reg + 2'd1;
                            end
                        end
                    endcase
                end
            end
            S_ROOTP:
            begin
                sx_next    = acc_reg[SW+tpca_pkg::SQ_SHIFT-1:tpca_pkg::SQ_SHIFT];
                res_next   = '0;
                bit_next   = SW'(1) << (SW - 2);
                cnt_next   = CW'(C + 2);
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (sx_reg >= tsum)
                begin
                    sx_next  = sx_reg - tsum;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                rslt_next.separation = (over_reg || root_big) ? {C{1'b1}} : root[C-1:0];
                rslt_next.mid_x      = mid_reg[0];
                rslt_next.mid_y      = mid_reg[1];
                rslt_next.mid_z      = mid_reg[2];
                rslt_next.mid_time   = t_reg;
                rslt_next.status     = (sat_reg || root_big) ? tpca_pkg::ST_SAT
                                                             : tpca_pkg::ST_OK;
                state_next           = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_next       = rslt_reg;
                    out_valid_next = 1'b1;
                    job_rd         = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        result = out_reg;
        empty  = !out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= 2'd0;
            ph_reg        <= 2'd0;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            den_reg       <= '0;
            n_reg         <= '0;
            rem_reg       <= '0;
            nlow_reg      <= '0;
            q_reg         <= '0;
            neg_reg       <= 1'b0;
            cnt_reg       <= '0;
            t_reg         <= '0;
            sat_reg       <= 1'b0;
            over_reg      <= 1'b0;
            tmp_reg       <= '0;
            p2_reg        <= '0;
            mag_reg       <= '0;
            mid_reg       <= '0;
            sx_reg        <= '0;
            res_reg       <= '0;
            bit_reg       <= '0;
            rslt_reg      <= '0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            ph_reg        <= ph_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            den_reg       <= den_next;
            n_reg         <= n_next;
            rem_reg       <= rem_next;
            nlow_reg      <= nlow_next;
            q_reg         <= q_next;
            neg_reg       <= neg_next;
            cnt_reg       <= cnt_next;
            t_reg         <= t_next;
            sat_reg       <= sat_next;
            over_reg      <= over_next;
            tmp_reg       <= tmp_next;
            p2_reg        <= p2_next;
            mag_reg       <= mag_next;
            mid_reg       <= mid_next;
            sx_reg        <= sx_next;
            res_reg       <= res_next;
            bit_reg       <= bit_next;
            rslt_reg      <= rslt_next;
            out_reg       <= out_next;
        end
    end

endmodule
